// ===== rtl/sre_pkg.sv =====
// Shared types, constants and helpers for the simple RISC instruction executor.
// Used by sre_alu and simple_risc_instruction_executor; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sre_pkg;

   localparam int MEM_WORDS = 4096;
   localparam int NUM_REGS  = 32;

   localparam int RegIdxW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int MemAddrW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   localparam logic [3:0] OP_STORE = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_LDR   = 4'd2;
   localparam logic [3:0] OP_STR   = 4'd3;
   localparam logic [3:0] OP_MOVC  = 4'd4;
   localparam logic [3:0] OP_ADD   = 4'd5;
   localparam logic [3:0] OP_ADDL  = 4'd6;
   localparam logic [3:0] OP_SUB   = 4'd7;
   localparam logic [3:0] OP_SUBL  = 4'd8;
   localparam logic [3:0] OP_MUL   = 4'd9;
   localparam logic [3:0] OP_AND   = 4'd10;
   localparam logic [3:0] OP_OR    = 4'd11;
   localparam logic [3:0] OP_EXOR  = 4'd12;

   typedef struct packed {
      logic [3:0]         command;
      logic [4:0]         dest_index;
      logic [4:0]         src_a_index;
      logic [4:0]         src_b_index;
      logic [4:0]         src_c_index;
      logic signed [31:0] immediate;
   } sre_req_type;

   typedef struct packed {
      logic               reg_written;
      logic [4:0]         reg_index;
      logic signed [31:0] reg_value;
      logic               mem_written;
      logic [11:0]        mem_word_addr;
      logic signed [31:0] mem_value;
      logic               address_fault;
   } sre_rsp_type;

   // Execute-stage results handed from the ALU to the top level
   typedef struct packed {
      logic        reg_written;
      logic        load_ok;
      logic        store_ok;
      logic [31:0] value;
      logic [31:0] addr;
      logic [11:0] mem_word_addr;
      logic [31:0] mem_value;
      logic        fault;
   } sre_exec_type;

   // Fold a 5-bit register number onto the implemented register count
   function automatic logic [RegIdxW-1:0] reg_slot(input logic [4:0] idx);
      logic [5:0] s;
      s = {1'b0, idx};
      for (int i = 0; i < 4; i++) begin
         if (s >= 6'(NUM_REGS)) begin
            s = s - 6'(NUM_REGS);
         end
      end
      return s[RegIdxW-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sre_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module sre_ram #(
   parameter int Width = 32,
   parameter int Depth = 16,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sre_alu.sv =====
// Execute logic: ALU, multiplier, address generation and range check.
// Depends on sre_pkg for opcodes, memory size and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module sre_alu
   import sre_pkg::*;
(
   input  wire logic [3:0]   cmd,
   input  wire logic [31:0]  op_a,
   input  wire logic [31:0]  op_b,
   input  wire logic [31:0]  op_c,
   input  wire logic [31:0]  imm,
   output sre_exec_type      result
);

   logic        is_mem;
   logic        is_store;
   logic        wr_alu;
   logic [31:0] alu_value;
   logic [31:0] addr;
   logic        fault;

   always_comb begin
      is_mem    = 1'b0;
      is_store  = 1'b0;
      wr_alu    = 1'b0;
      alu_value = '0;
      addr      = '0;
      unique case (cmd)
         OP_STORE: begin
            is_mem   = 1'b1;
            is_store = 1'b1;
            addr     = op_b + imm;
         end
         OP_STR: begin
            is_mem   = 1'b1;
            is_store = 1'b1;
            addr     = op_b + op_c;
         end
         OP_LOAD: begin
            is_mem = 1'b1;
            addr   = op_a + imm;
         end
         OP_LDR: begin
            is_mem = 1'b1;
            addr   = op_a + op_b;
         end
         OP_MOVC: begin
            wr_alu    = 1'b1;
            alu_value = imm;
         end
         OP_ADD: begin
            wr_alu    = 1'b1;
            alu_value = op_a + op_b;
         end
         OP_ADDL: begin
            wr_alu    = 1'b1;
            alu_value = op_a + imm;
         end
         OP_SUB: begin
            wr_alu    = 1'b1;
            alu_value = op_a - op_b;
         end
         OP_SUBL: begin
            wr_alu    = 1'b1;
            alu_value = op_a - imm;
         end
         OP_MUL: begin
            wr_alu    = 1'b1;
            alu_value = op_a * op_b;
         end
         OP_AND: begin
            wr_alu    = 1'b1;
            alu_value = op_a & op_b;
         end
         OP_OR: begin
            wr_alu    = 1'b1;
            alu_value = op_a | op_b;
         end
         OP_EXOR: begin
            wr_alu    = 1'b1;
            alu_value = op_a ^ op_b;
         end
         default: begin
            is_mem = 1'b0;
         end
      endcase
   end

   // Unsigned compare also catches negative addresses
   assign fault = is_mem && (addr >= 32'(MEM_WORDS));

   always_comb begin
      result.load_ok       = is_mem && !is_store && !fault;
      result.store_ok      = is_store && !fault;
      result.reg_written   = wr_alu || result.load_ok;
      result.value         = alu_value;
      result.addr          = addr;
      result.mem_word_addr = is_mem ? addr[11:0] : 12'd0;
      result.mem_value     = result.store_ok ? op_a : 32'd0;
      result.fault         = fault;
   end

endmodule

`default_nettype wire

// ===== rtl/simple_risc_instruction_executor.sv =====
// Simple RISC instruction executor: two-stage pipeline, register read then execute.
// An accepted request is registered in stage 1, then in the stage 2 result register that
// drives rsp_valid. Throughput: one instruction per cycle unless rsp_stall or the clear
// pass holds the pipe, bounded by the single-pass execute stage between the registered
// register-file read and the result register.
// Reset: pipeline empties, register file reads zero through per-entry valid bits,
// data memory is swept to zero over all MEM_WORDS (4096) words with req_stall high.
`timescale 1ns / 1ps
`default_nettype none

module simple_risc_instruction_executor
   import sre_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire sre_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output sre_rsp_type      rsp_payload
);

   // ---------------------------------------------------------------------
   // Pipeline control: the whole pipe advances unless the result register
   // holds a transaction that the consumer is stalling.
   // ---------------------------------------------------------------------
   logic advance;
   logic accept;
   logic clear_busy_ff;
   logic clear_busy_in;
   logic [MemAddrW-1:0] clear_cnt_ff;
   logic [MemAddrW-1:0] clear_cnt_in;

   logic s1_valid_ff;
   logic s2_valid_ff;

   assign advance   = !(s2_valid_ff && rsp_stall);
   assign req_stall = clear_busy_ff || !advance;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Register read: three RAM copies, one per source operand, all written
   // with the same write-back data. Valid bits stand in for reset-to-zero.
   // ---------------------------------------------------------------------
   logic [RegIdxW-1:0] slot_a;
   logic [RegIdxW-1:0] slot_b;
   logic [RegIdxW-1:0] slot_c;
   logic [RegIdxW-1:0] slot_d;

   assign slot_a = reg_slot(req_payload.src_a_index);
   assign slot_b = reg_slot(req_payload.src_b_index);
   assign slot_c = reg_slot(req_payload.src_c_index);
   assign slot_d = reg_slot(req_payload.dest_index);

   logic               rf_we;
   logic [RegIdxW-1:0] rf_waddr;
   logic [31:0]        rf_wdata;
   logic [31:0]        rf_q_a;
   logic [31:0]        rf_q_b;
   logic [31:0]        rf_q_c;
   logic [NUM_REGS-1:0] rf_valid_ff;

   sre_ram #(.Width(32), .Depth(NUM_REGS)) u_rf_a (
      .clock  (clock),
      .wr_en  (rf_we),
      .wr_addr(rf_waddr),
      .wr_data(rf_wdata),
      .rd_en  (advance),
      .rd_addr(slot_a),
      .rd_data(rf_q_a)
   );

   sre_ram #(.Width(32), .Depth(NUM_REGS)) u_rf_b (
      .clock  (clock),
      .wr_en  (rf_we),
      .wr_addr(rf_waddr),
      .wr_data(rf_wdata),
      .rd_en  (advance),
      .rd_addr(slot_b),
      .rd_data(rf_q_b)
   );

   sre_ram #(.Width(32), .Depth(NUM_REGS)) u_rf_c (
      .clock  (clock),
      .wr_en  (rf_we),
      .wr_addr(rf_waddr),
      .wr_data(rf_wdata),
      .rd_en  (advance),
      .rd_addr(slot_c),
      .rd_data(rf_q_c)
   );

   // ---------------------------------------------------------------------
   // Stage 1 registers: decoded fields plus the valid bits sampled with
   // the RAM read.
   // ---------------------------------------------------------------------
   logic [3:0]         s1_cmd_ff;
   logic [RegIdxW-1:0] s1_dst_ff;
   logic [RegIdxW-1:0] s1_sa_ff;
   logic [RegIdxW-1:0] s1_sb_ff;
   logic [RegIdxW-1:0] s1_sc_ff;
   logic [31:0]        s1_imm_ff;
   logic               s1_rva_ff;
   logic               s1_rvb_ff;
   logic               s1_rvc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_cmd_ff <= req_payload.command;
         s1_dst_ff <= slot_d;
         s1_sa_ff  <= slot_a;
         s1_sb_ff  <= slot_b;
         s1_sc_ff  <= slot_c;
         s1_imm_ff <= req_payload.immediate;
      end
      if (advance) begin
         s1_rva_ff <= rf_valid_ff[slot_a];
         s1_rvb_ff <= rf_valid_ff[slot_b];
         s1_rvc_ff <= rf_valid_ff[slot_c];
      end
   end

   // ---------------------------------------------------------------------
   // Write-back and bypass. The RAM read returns the old word when the
   // write lands on the same edge, so hold that write in the last-write
   // register; the instruction in stage 2 is newer still and wins.
   // ---------------------------------------------------------------------
   logic               s2_wr_ff;
   logic               s2_load_ff;
   logic [RegIdxW-1:0] s2_idx_ff;
   logic [31:0]        s2_value_ff;
   logic               s2_memwr_ff;
   logic [11:0]        s2_addr_ff;
   logic [31:0]        s2_memval_ff;
   logic               s2_fault_ff;
   logic [31:0]        dram_q;
   logic [31:0]        s2_result;
   logic               s2_fwd;

   logic               lw_valid_ff;
   logic [RegIdxW-1:0] lw_idx_ff;
   logic [31:0]        lw_value_ff;

   assign s2_result = s2_load_ff ? dram_q : s2_value_ff;
   assign s2_fwd    = s2_valid_ff && s2_wr_ff;

   // Commit when the result transaction leaves the output register
   assign rf_we    = s2_fwd && advance;
   assign rf_waddr = s2_idx_ff;
   assign rf_wdata = s2_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
         lw_valid_ff <= 1'b0;
      end else begin
         if (rf_we) begin
            rf_valid_ff[s2_idx_ff] <= 1'b1;
         end
         if (advance) begin
            lw_valid_ff <= s2_fwd;
         end
      end
      if (advance) begin
         lw_idx_ff   <= s2_idx_ff;
         lw_value_ff <= s2_result;
      end
   end

   function automatic logic [31:0] bypass(
      input logic [RegIdxW-1:0] idx,
      input logic [31:0]        ram_q,
      input logic               ram_ok,
      input logic               lw_hit_ok,
      input logic [RegIdxW-1:0] lw_idx,
      input logic [31:0]        lw_val,
      input logic               s2_hit_ok,
      input logic [RegIdxW-1:0] s2_idx,
      input logic [31:0]        s2_val
   );
      logic [31:0] v;
      v = ram_ok ? ram_q : 32'd0;
      if (lw_hit_ok && (lw_idx == idx)) begin
         v = lw_val;
      end
      if (s2_hit_ok && (s2_idx == idx)) begin
         v = s2_val;
      end
      return v;
   endfunction

   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [31:0] op_c;

   assign op_a = bypass(s1_sa_ff, rf_q_a, s1_rva_ff, lw_valid_ff, lw_idx_ff, lw_value_ff,
                        s2_fwd, s2_idx_ff, s2_result);
   assign op_b = bypass(s1_sb_ff, rf_q_b, s1_rvb_ff, lw_valid_ff, lw_idx_ff, lw_value_ff,
                        s2_fwd, s2_idx_ff, s2_result);
   assign op_c = bypass(s1_sc_ff, rf_q_c, s1_rvc_ff, lw_valid_ff, lw_idx_ff, lw_value_ff,
                        s2_fwd, s2_idx_ff, s2_result);

   // ---------------------------------------------------------------------
   // Execute
   // ---------------------------------------------------------------------
   sre_exec_type ex;

   sre_alu u_alu (
      .cmd   (s1_cmd_ff),
      .op_a  (op_a),
      .op_b  (op_b),
      .op_c  (op_c),
      .imm   (s1_imm_ff),
      .result(ex)
   );

   // ---------------------------------------------------------------------
   // Data memory. Stores write from stage 1 and loads read from stage 1, so
   // a load always sees every older store without a bypass. The clear pass
   // owns the write port right after reset.
   // ---------------------------------------------------------------------
   logic                dram_we;
   logic [MemAddrW-1:0] dram_waddr;
   logic [31:0]         dram_wdata;
   logic                store_go;

   assign store_go   = s1_valid_ff && ex.store_ok && advance;
   assign dram_we    = clear_busy_ff || store_go;
   assign dram_waddr = clear_busy_ff ? clear_cnt_ff : ex.addr[MemAddrW-1:0];
   assign dram_wdata = clear_busy_ff ? 32'd0 : op_a;

   sre_ram #(.Width(32), .Depth(MEM_WORDS)) u_dram (
      .clock  (clock),
      .wr_en  (dram_we),
      .wr_addr(dram_waddr),
      .wr_data(dram_wdata),
      .rd_en  (advance),
      .rd_addr(ex.addr[MemAddrW-1:0]),
      .rd_data(dram_q)
   );

   always_comb begin
      clear_cnt_in  = clear_cnt_ff + MemAddrW'(1);
      clear_busy_in = clear_busy_ff && (clear_cnt_ff != MemAddrW'(MEM_WORDS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
      end else if (clear_busy_ff) begin
         clear_busy_ff <= clear_busy_in;
         clear_cnt_ff  <= clear_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: result register. Load data joins from the memory read port,
   // which holds its word while the stage is stalled.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_wr_ff     <= ex.reg_written;
         s2_load_ff   <= ex.load_ok;
         s2_idx_ff    <= s1_dst_ff;
         s2_value_ff  <= ex.value;
         s2_memwr_ff  <= ex.store_ok;
         s2_addr_ff   <= ex.mem_word_addr;
         s2_memval_ff <= ex.mem_value;
         s2_fault_ff  <= ex.fault;
      end
   end

   assign rsp_valid = s2_valid_ff;

   always_comb begin
      rsp_payload.reg_written   = s2_wr_ff;
      rsp_payload.reg_index     = s2_wr_ff ? 5'(s2_idx_ff) : 5'd0;
      rsp_payload.reg_value     = s2_wr_ff ? s2_result : 32'd0;
      rsp_payload.mem_written   = s2_memwr_ff;
      rsp_payload.mem_word_addr = s2_addr_ff;
      rsp_payload.mem_value     = s2_memval_ff;
      rsp_payload.address_fault = s2_fault_ff;
   end

endmodule

`default_nettype wire
